>>> hdl/ctnl_pkg.sv
// ----------------------------------------------------------------------------
// ctnl_pkg
// Shared constants and types of the child table next-link unit.
// ----------------------------------------------------------------------------
package ctnl_pkg;

  // Longest array handled; later items of the same array are dropped.
  localparam int unsigned MAX_LEN = 65536;

  localparam int unsigned LcpW  = 16;
  localparam int unsigned PosW  = 16;
  localparam int unsigned AddrW = $clog2(MAX_LEN);
  localparam int unsigned CntW  = $clog2(MAX_LEN + 1);

  // One stack entry: position in the upper half, lcp in the lower half.
  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [LcpW-1:0] lcp;
  } ctnl_entry_t;

  localparam int unsigned EntryW = $bits(ctnl_entry_t);

  typedef enum logic [1:0] {
    STK_NONE,
    STK_PUSH,
    STK_POP,
    STK_REPLACE
  } ctnl_stk_op_e;

  typedef struct packed {
    logic         clear;   // empty the stack before the operation
    ctnl_stk_op_e op;
    ctnl_entry_t  entry;
  } ctnl_stk_cmd_t;

  typedef struct packed {
    logic        empty;
    ctnl_entry_t tos;      // valid when not empty
  } ctnl_stk_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESOLVE,
    ST_FETCH
  } ctnl_state_e;

endpackage

>>> hdl/ctnl_in_if.sv
// ----------------------------------------------------------------------------
// ctnl_in_if
// Request channel carrying one LCP value and the start-of-array flag.
// ----------------------------------------------------------------------------
interface ctnl_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] lcp_value;
  logic        start_of_array;

  modport source (output valid, output lcp_value, output start_of_array, input ready);
  modport sink   (input valid, input lcp_value, input start_of_array, output ready);
endinterface

>>> hdl/ctnl_out_if.sv
// ----------------------------------------------------------------------------
// ctnl_out_if
// Result channel carrying one next link (owner position, next position).
// ----------------------------------------------------------------------------
interface ctnl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] owner_index;
  logic [15:0] next_index;

  modport source (output valid, output owner_index, output next_index, input ready);
  modport sink   (input valid, input owner_index, input next_index, output ready);
endinterface

>>> hdl/ctnl_ram.sv
// ----------------------------------------------------------------------------
// ctnl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ctnl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ctnl_stack.sv
// ----------------------------------------------------------------------------
// ctnl_stack
// (position, lcp) stack in RAM with a cached top entry and an entry count.
// ----------------------------------------------------------------------------
module ctnl_stack (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctnl_pkg::ctnl_stk_cmd_t cmd_i,
  output ctnl_pkg::ctnl_stk_sts_t sts_o
);
  import ctnl_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] base;
  ctnl_entry_t     tos_q, tos_d;
  logic            fetch_q, fetch_d;

  logic              we;
  logic [AddrW-1:0]  waddr;
  logic              re;
  logic [AddrW-1:0]  raddr;
  logic [EntryW-1:0] rdata;

  always_comb begin
    base    = cmd_i.clear ? '0 : cnt_q;
    cnt_d   = base;
    tos_d   = fetch_q ? ctnl_entry_t'(rdata) : tos_q;
    fetch_d = 1'b0;
    we      = 1'b0;
    waddr   = base[AddrW-1:0];
    re      = 1'b0;
    raddr   = AddrW'(cnt_q - CntW'(2));
    case (cmd_i.op)
      STK_PUSH: begin
        // count never exceeds the position, so there is always room
        we    = 1'b1;
        cnt_d = base + CntW'(1);
        tos_d = cmd_i.entry;
      end
      STK_REPLACE: begin
        we    = 1'b1;
        waddr = AddrW'(cnt_q - CntW'(1));
        tos_d = cmd_i.entry;
      end
      STK_POP: begin
        cnt_d   = cnt_q - CntW'(1);
        re      = (cnt_q > CntW'(1));
        fetch_d = re;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      fetch_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      fetch_q <= fetch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
  end

  ctnl_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.entry),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sts_o.empty = (cnt_q == '0);
  assign sts_o.tos   = tos_q;

endmodule

>>> hdl/child_table_next_links_unit.sv
// ----------------------------------------------------------------------------
// child_table_next_links_unit
// Builds the "next" links of an enhanced suffix array child table from an
// LCP array streamed in one value per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : valid/ready request channel; each request carries lcp_value and
//           start_of_array. Raise start_of_array on the first value of an
//           array: it clears the stack and the position counter.
//   res_o : valid/ready result channel; zero or one link per request,
//           (owner_index, next_index), in input order.
// Timing:
//   Position 0 of an array is finished in the accepting cycle.
//   Any other position is taken in ST_IDLE and decided in ST_RESOLVE;
//   every larger-lcp entry it pops adds an ST_FETCH and another ST_RESOLVE
//   step; closing an equal sibling is folded into the final step. The pop
//   loop is bound by the registered read of the stack RAM. Each position is
//   pushed once and popped at most once.
//   A result appears in the output register in the cycle after the deciding
//   step and holds until taken.
// Reset:
//   rst_ni clears the stack count, the position counter and the result
//   valid. Stack RAM contents are not cleared; only entries below the count
//   are ever read.
// Stall:
//   A new request is taken only in the idle state with the result register
//   free or being drained, so a stalled receiver holds off the input side.
//   Requests beyond MAX_LEN positions of one array are taken and dropped.
// ----------------------------------------------------------------------------
module child_table_next_links_unit (
  input  logic   clk_i,
  input  logic   rst_ni,
  ctnl_in_if.sink  in_i,
  ctnl_out_if.source res_o
);
  import ctnl_pkg::*;

  ctnl_state_e      state_q, state_d;
  logic [CntW-1:0]  pos_q, pos_d;        // position of the next request
  logic [LcpW-1:0]  lcp_q, lcp_d;        // lcp of the item being resolved
  logic [PosW-1:0]  ipos_q, ipos_d;      // position of the item being resolved

  logic             res_valid_q, res_valid_d;
  logic [PosW-1:0]  owner_q, owner_d;
  logic [PosW-1:0]  next_q, next_d;

  ctnl_stk_cmd_t    stk_cmd;
  ctnl_stk_sts_t    stk_sts;

  logic             accept;
  logic             emit;
  logic [PosW-1:0]  emit_owner;
  logic [PosW-1:0]  emit_next;

  // Take a request only when idle and the result slot can absorb a link.
  assign in_i.ready = (state_q == ST_IDLE) && (!res_valid_q || res_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    lcp_d         = lcp_q;
    ipos_d        = ipos_q;
    emit          = 1'b0;
    emit_owner    = '0;
    emit_next     = '0;
    stk_cmd.clear = 1'b0;
    stk_cmd.op    = STK_NONE;
    stk_cmd.entry = '{pos: ipos_q, lcp: lcp_q};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.start_of_array || (pos_q == '0)) begin
            // first position of an array: self link, then push (0, lcp)
            stk_cmd.clear = in_i.start_of_array;
            stk_cmd.op    = STK_PUSH;
            stk_cmd.entry = '{pos: '0, lcp: in_i.lcp_value};
            emit          = 1'b1;
            pos_d         = CntW'(1);
          end else if (pos_q < CntW'(MAX_LEN)) begin
            lcp_d   = in_i.lcp_value;
            ipos_d  = pos_q[PosW-1:0];
            pos_d   = pos_q + CntW'(1);
            state_d = ST_RESOLVE;
          end
          // past MAX_LEN: dropped, nothing changes
        end
      end

      ST_RESOLVE: begin
        if (!stk_sts.empty && (lcp_q < stk_sts.tos.lcp)) begin
          // larger lcp on top: pop, wait for the new top from RAM
          stk_cmd.op = STK_POP;
          state_d    = ST_FETCH;
        end else if (!stk_sts.empty && (lcp_q == stk_sts.tos.lcp)) begin
          // equal sibling: pop it and push us in one step = overwrite top
          stk_cmd.op = STK_REPLACE;
          emit       = 1'b1;
          emit_owner = stk_sts.tos.pos;
          emit_next  = ipos_q;
          state_d    = ST_IDLE;
        end else begin
          stk_cmd.op = STK_PUSH;
          state_d    = ST_IDLE;
        end
      end

      ST_FETCH: begin
        state_d = ST_RESOLVE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register
  always_comb begin
    res_valid_d = res_valid_q;
    owner_d     = owner_q;
    next_d      = next_q;
    if (emit) begin
      res_valid_d = 1'b1;
      owner_d     = emit_owner;
      next_d      = emit_next;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lcp_q   <= lcp_d;
    ipos_q  <= ipos_d;
    owner_q <= owner_d;
    next_q  <= next_d;
  end

  ctnl_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (stk_cmd),
    .sts_o  (stk_sts)
  );

  assign res_o.valid       = res_valid_q;
  assign res_o.owner_index = owner_q;
  assign res_o.next_index  = next_q;

endmodule

>>> bench/tb_child_table_next_links_unit.sv
// ----------------------------------------------------------------------------
// tb_child_table_next_links_unit
// Self-checking bench for the child table next-link unit: directed probes,
// then random LCP arrays under random stalls. Every accepted link is checked
// against hand-typed probe rows or an in-bench stack predictor.
// ----------------------------------------------------------------------------
module tb_child_table_next_links_unit;
  import ctnl_pkg::*;

  // Generous bound for a full run of the bench.
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned RandomRequests = 2000;
  localparam int unsigned EndSettle      = 1000;   // deepest pop loop plus stalls

  typedef struct packed {
    logic [PosW-1:0] owner;
    logic [PosW-1:0] succ;
  } link_t;

  // One directed probe. Rows with typed set carry an expectation read off
  // by hand; the others are left to the predictor.
  typedef struct packed {
    logic [LcpW-1:0] lcp;
    logic            start;
    bit              typed;
    bit              hit;
    logic [PosW-1:0] owner;
    logic [PosW-1:0] succ;
  } probe_t;

  localparam int NumProbes = 20;
  localparam probe_t Probes [NumProbes] = '{
    // position 0 links to itself
    '{16'h0000, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0},
    '{16'hFFFF, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0},
    // equal top at max lcp
    '{16'hFFFF, 1'b0, 1'b1, 1'b1, 16'd1, 16'd2},
    '{16'h0005, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{16'h0000, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{16'h0000, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    // new array whose first lcp is the max: later values empty the stack
    '{16'hFFFF, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0},
    '{16'h8000, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0},
    '{16'h0000, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0},
    '{16'h0000, 1'b0, 1'b1, 1'b1, 16'd2, 16'd3},
    // back-to-back starts
    '{16'h1234, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0},
    '{16'h0000, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0},
    // alternating bit patterns
    '{16'hAAAA, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{16'h5555, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{16'hAAAA, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{16'h5555, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{16'h0001, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{16'h0000, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0}
  };

  logic clk_i;
  logic rst_ni;

  ctnl_in_if  req_if ();
  ctnl_out_if link_if ();

  child_table_next_links_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .res_o  (link_if)
  );

  // Predictor state: sibling stack of (position, lcp), depth, array position.
  ctnl_entry_t sib_stack [MAX_LEN];
  int unsigned sib_depth;
  int unsigned array_pos;
  int unsigned deepest;

  link_t pending_links [$];   // links still owed by the unit, oldest first
  int unsigned requests_sent;
  int unsigned links_checked;
  int unsigned arrays_sent;
  int unsigned errors;
  bit          calm;          // no idling on either side while set

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Walks the sibling stack for one request, returns 1 with the link when
  // an equal-lcp sibling is closed (or for the self-link of position 0).
  function automatic bit predict_link(input logic [LcpW-1:0] lcp, input logic start,
                                      output link_t link);
    bit              hit;
    logic [PosW-1:0] here;
    hit  = 1'b0;
    link = '0;
    if (start) begin
      sib_depth = 0;
      array_pos = 0;
    end
    // past the array limit: dropped, state untouched
    if (array_pos >= MAX_LEN) return 1'b0;
    here = array_pos[PosW-1:0];
    if (array_pos == 0) begin
      hit = 1'b1;
    end else begin
      // pop every deeper sibling; may run the stack empty
      while (sib_depth > 0 && lcp < sib_stack[sib_depth-1].lcp) sib_depth--;
      if (sib_depth > 0 && lcp == sib_stack[sib_depth-1].lcp) begin
        sib_depth--;
        hit        = 1'b1;
        link.owner = sib_stack[sib_depth].pos;
        link.succ  = here;
      end
    end
    if (sib_depth < MAX_LEN) begin
      sib_stack[sib_depth] = '{pos: here, lcp: lcp};
      sib_depth++;
    end
    if (sib_depth > deepest) deepest = sib_depth;
    array_pos++;
    return hit;
  endfunction

  // Offers one request, with an occasional idle gap ahead of it, and books
  // the expected link once the unit takes it.
  task automatic send_request(input logic [LcpW-1:0] lcp, input logic start,
                              input bit typed, input bit typed_hit,
                              input logic [PosW-1:0] typed_owner,
                              input logic [PosW-1:0] typed_succ);
    bit    hit;
    link_t link;
    if (!calm && $urandom_range(0, 99) < 7) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.lcp_value      <= lcp;
    req_if.start_of_array <= start;
    do @(posedge clk_i); while (!req_if.ready);
    // predictor runs on every request to keep its stack in step
    hit = predict_link(lcp, start, link);
    if (typed) begin
      hit        = typed_hit;
      link.owner = typed_owner;
      link.succ  = typed_succ;
    end
    if (hit) pending_links.push_back(link);
    requests_sent++;
  endtask

  // Holds the request side off until every booked link has been taken.
  // Its wait loop runs before its test, so valid is never driven twice in a step.
  task automatic wait_links_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_links.size() != 0);
  endtask

  // Result side: random back-pressure, none while calm.
  initial begin : link_ready_drive
    link_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      link_if.ready <= calm || ($urandom_range(0, 99) >= 7);
    end
  end

  // Every taken link is compared with the oldest booked one.
  always @(posedge clk_i) begin : check_links
    link_t want;
    if (rst_ni && link_if.valid && link_if.ready) begin
      if (pending_links.size() == 0) begin
        $display("%0t: unexpected link: expected none, got owner=%0d next=%0d",
                 $time, link_if.owner_index, link_if.next_index);
        errors++;
      end else begin
        want = pending_links.pop_front();
        if (link_if.owner_index !== want.owner) begin
          $display("%0t: owner_index mismatch: expected %0d, got %0d",
                   $time, want.owner, link_if.owner_index);
          errors++;
        end
        if (link_if.next_index !== want.succ) begin
          $display("%0t: next_index mismatch: expected %0d, got %0d",
                   $time, want.succ, link_if.next_index);
          errors++;
        end
        links_checked++;
      end
    end
  end

  // Watchdog.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("%0t: timeout after %0d cycles, %0d links still owed",
             $time, CycleLimit, pending_links.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    int unsigned     i;
    int unsigned     arr_len;
    int unsigned     mode;
    int unsigned     random_sent;
    int unsigned     drain;
    logic [LcpW-1:0] base;
    logic [LcpW-1:0] lcp;
    logic            start;

    // known values on every input from time 0
    rst_ni                <= 1'b0;
    req_if.valid          <= 1'b0;
    req_if.lcp_value      <= '0;
    req_if.start_of_array <= 1'b0;
    sib_depth     = 0;
    array_pos     = 0;
    deepest       = 0;
    requests_sent = 0;
    links_checked = 0;
    arrays_sent   = 0;
    errors        = 0;
    random_sent   = 0;
    calm          = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed probes.
    for (i = 0; i < NumProbes; i++) begin
      send_request(Probes[i].lcp, Probes[i].start, Probes[i].typed, Probes[i].hit,
                   Probes[i].owner, Probes[i].succ);
    end
    wait_links_drained();

    // Random arrays. Mostly short arrays over a narrow lcp range so equal
    // siblings are common; some wide and near-extreme values too.
    while (random_sent < RandomRequests) begin
      arr_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300)
                                            : $urandom_range(1, 40);
      mode = $urandom_range(0, 9);
      base = LcpW'($urandom_range(0, 16'hFFF7));
      for (i = 0; i < arr_len; i++) begin
        case (mode)
          0, 1, 2, 3, 4, 5: lcp = LcpW'($urandom_range(0, 7));
          6, 7:             lcp = base + LcpW'($urandom_range(0, 7));
          8:                lcp = LcpW'($urandom());
          default:          lcp = $urandom_range(0, 1) ? 16'hFFFF - LcpW'($urandom_range(0, 3))
                                                       : LcpW'($urandom_range(0, 3));
        endcase
        // now and then an array runs on without a fresh start
        start = (i == 0) && ($urandom_range(0, 9) != 0);
        calm  = (random_sent >= 700) && (random_sent < 1100);
        send_request(lcp, start, 1'b0, 1'b0, 16'd0, 16'd0);
        random_sent++;
        if (random_sent % 250 == 0) wait_links_drained();
      end
      arrays_sent++;
    end
    calm = 1'b0;

    // Drain, then give the last pop loop time to surface anything stray.
    req_if.valid <= 1'b0;
    drain = 0;
    while (pending_links.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (EndSettle) @(posedge clk_i);
    if (pending_links.size() != 0) begin
      $display("%0t: %0d links never arrived: expected owner=%0d next=%0d, got none",
               $time, pending_links.size(), pending_links[0].owner, pending_links[0].succ);
      errors++;
    end

    $display("Run: %0d requests in %0d arrays, %0d links checked, deepest stack %0d",
             requests_sent, arrays_sent, links_checked, deepest);
    $display("Run: self-links, emptied stacks, equal-lcp closes, arrays without a fresh start");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ctnl_pkg.sv
hdl/ctnl_in_if.sv
hdl/ctnl_out_if.sv
hdl/ctnl_ram.sv
hdl/ctnl_stack.sv
hdl/child_table_next_links_unit.sv
bench/tb_child_table_next_links_unit.sv
